// File: sv/hkcd_pkg.sv
// Shared types and constants for the hotkey chord detector.
`timescale 1ns / 1ps

package hkcd_pkg;

    localparam int NUM_SHORTCUTS_DEF     = 7;
    localparam int KEYS_PER_SHORTCUT_DEF = 4;

    localparam int KEY_SPACE  = 256;
    localparam int KEY_W      = $clog2(KEY_SPACE);
    localparam int KEYS_MAX   = 4;
    localparam int POS_W      = 2;
    localparam int CNT_W      = 3;
    localparam int CODE_LSB   = 4;
    localparam int SLOT_REG_W = CODE_LSB + KEYS_MAX * KEY_W;
    localparam int SLOT_REGS  = 7;
    localparam int IDX_W      = 3;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_LISTEN = CFG_IDX_W'(SLOT_REGS);

    typedef enum logic {
        OP_KEY,
        OP_SCAN
    } op_t;

    typedef struct packed {
        op_t              opcode;
        logic [KEY_W-1:0] key_code;
        logic             key_is_down;
        logic             window_focused;
    } in_t;

    typedef struct packed {
        logic [IDX_W-1:0] shortcut_index;
        logic             fired;
        logic             last_of_scan;
    } out_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SLOT,
        ST_EVAL,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic clr_step;
        logic in_take;
        logic slot_start;
        logic eval;
        logic done_load;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic scan_req;
        logic slot_empty;
        logic eval_stop;
        logic out_free;
        logic last_slot;
    } stat_t;

endpackage

// File: sv/hotkey_chord_detector.sv
// Top level of the hotkey chord detector: controller, datapath and checks.
`timescale 1ns / 1ps

// Keeps a 256-key down map and up to seven shortcut registers. A key event request
// (opcode 0) writes one map bit and is taken whenever the detector is idle. A scan request
// (opcode 1) walks the shortcuts in order and returns one result per shortcut,
// last_of_scan marking the final one; the keys of each shortcut are read one at a
// time, last to first, through the key map RAM's single read port, and a finished
// result waits in place while the result side stalls.
// No request is taken during a scan. After reset a clearing pass zeroes every
// entry of the key map; requests stall during it, configuration writes are taken.
module hotkey_chord_detector #(
    parameter int NUM_SHORTCUTS     = hkcd_pkg::NUM_SHORTCUTS_DEF,
    parameter int KEYS_PER_SHORTCUT = hkcd_pkg::KEYS_PER_SHORTCUT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_stall,
    input  hkcd_pkg::in_t                   item,
    output logic                            result_valid,
    input  logic                            result_stall,
    output hkcd_pkg::out_t                  result,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [hkcd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hkcd_pkg::SLOT_REG_W-1:0] cfg_data
);

    hkcd_pkg::cmd_t  cmd;
    hkcd_pkg::stat_t stat;

    assign cfg_ready = 1'b1;

    hkcd_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .stat       (stat),
        .cmd        (cmd)
    );

    hkcd_datapath #(
        .NUM_SHORTCUTS     (NUM_SHORTCUTS),
        .KEYS_PER_SHORTCUT (KEYS_PER_SHORTCUT)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // the final result of a scan reports the highest shortcut, and only it
    a_last_marks_final: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.last_of_scan ==
            (result.shortcut_index == hkcd_pkg::IDX_W'(NUM_SHORTCUTS - 1))))
        else $error("last_of_scan does not match shortcut index");

    // an accepted scan blocks further requests while it runs
    a_scan_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall && item.opcode == hkcd_pkg::OP_SCAN) |=> item_stall)
        else $error("request taken while a scan is running");

    // hold a stalled result until it is taken
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> (result_valid && $stable(result)))
        else $error("stalled result changed");

endmodule

// File: sv/hkcd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module hkcd_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/hkcd_ctrl.sv
// Controller state machine: clearing pass, request intake and the shortcut walk.
`timescale 1ns / 1ps

module hkcd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  hkcd_pkg::stat_t   stat,
    output hkcd_pkg::cmd_t    cmd
);

    hkcd_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hkcd_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hkcd_pkg::ST_CLEAR:
            begin
                if (stat.clear_last)
                begin
                    state_next = hkcd_pkg::ST_IDLE;
                end
            end
            hkcd_pkg::ST_IDLE:
            begin
                if (item_valid && stat.scan_req)
                begin
                    state_next = hkcd_pkg::ST_SLOT;
                end
            end
            hkcd_pkg::ST_SLOT:
            begin
                state_next = stat.slot_empty ? hkcd_pkg::ST_DONE : hkcd_pkg::ST_EVAL;
            end
            hkcd_pkg::ST_EVAL:
            begin
                if (stat.eval_stop)
                begin
                    state_next = hkcd_pkg::ST_DONE;
                end
            end
            hkcd_pkg::ST_DONE:
            begin
                // hold until the output register can take the result
                if (stat.out_free)
                begin
                    state_next = stat.last_slot ? hkcd_pkg::ST_IDLE : hkcd_pkg::ST_SLOT;
                end
            end
            default:
            begin
                state_next = hkcd_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        item_stall     = (state_reg != hkcd_pkg::ST_IDLE);
        cmd.clr_step   = (state_reg == hkcd_pkg::ST_CLEAR);
        cmd.in_take    = (state_reg == hkcd_pkg::ST_IDLE) && item_valid;
        cmd.slot_start = (state_reg == hkcd_pkg::ST_SLOT);
        cmd.eval       = (state_reg == hkcd_pkg::ST_EVAL);
        cmd.done_load  = (state_reg == hkcd_pkg::ST_DONE) && stat.out_free;
    end

endmodule

// File: sv/hkcd_datapath.sv
// Datapath: key map RAM, shortcut registers, per-key history and result register.
`timescale 1ns / 1ps

module hkcd_datapath #(
    parameter int NUM_SHORTCUTS     = hkcd_pkg::NUM_SHORTCUTS_DEF,
    parameter int KEYS_PER_SHORTCUT = hkcd_pkg::KEYS_PER_SHORTCUT_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  hkcd_pkg::in_t                       item,
    input  logic                                cfg_we,
    input  logic [hkcd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [hkcd_pkg::SLOT_REG_W-1:0]     cfg_data,
    input  hkcd_pkg::cmd_t                      cmd,
    output hkcd_pkg::stat_t                     stat,
    output logic                                result_valid,
    input  logic                                result_stall,
    output hkcd_pkg::out_t                      result
);

    localparam int SLOT_W = (NUM_SHORTCUTS > 1) ? $clog2(NUM_SHORTCUTS) : 1;
    localparam int NREG   = (NUM_SHORTCUTS < hkcd_pkg::SLOT_REGS) ?
                            NUM_SHORTCUTS : hkcd_pkg::SLOT_REGS;
    localparam int KW     = hkcd_pkg::KEY_W;
    localparam int KM     = hkcd_pkg::KEYS_MAX;
    localparam int PW     = hkcd_pkg::POS_W;
    localparam int CW     = hkcd_pkg::CNT_W;
    localparam int RW     = hkcd_pkg::SLOT_REG_W;

    logic                 listen_reg, listen_next;
    logic [RW-1:0]        slot_reg [NREG];
    logic [RW-1:0]        slot_next [NREG];
    logic [KM-1:0]        held_reg [NREG];
    logic [KM-1:0]        held_next [NREG];
    logic [KW-1:0]        clr_cnt_reg, clr_cnt_next;
    logic [SLOT_W-1:0]    slot_cnt_reg, slot_cnt_next;
    logic [PW-1:0]        pos_reg, pos_next;
    logic [KM-1:0]        hist_reg, hist_next;
    logic                 release_reg, release_next;
    logic                 cond_reg, cond_next;
    logic                 released_reg, released_next;
    logic                 fail_reg, fail_next;
    logic                 empty_reg, empty_next;
    logic                 focused_reg, focused_next;
    logic                 result_valid_reg, result_valid_next;
    hkcd_pkg::out_t       result_reg, result_next;

    logic [RW-1:0]        sel;
    logic [KM-1:0]        sel_held;
    logic [KW-1:0]        code [KM];
    logic [CW-1:0]        key_cnt;
    logic [CW-1:0]        eff_cnt;
    logic [CW-1:0]        start_pos_wide;
    logic [PW-1:0]        rd_pos;
    logic                 slot_empty;
    logic                 last_slot;
    logic                 fired;

    logic                 ram_we;
    logic [KW-1:0]        ram_waddr;
    logic                 ram_wdata;
    logic [KW-1:0]        ram_raddr;
    logic                 ram_rdata;

    logic                 held;
    logic                 prev_held;
    logic [KM-1:0]        ev_hist;
    logic                 ev_cond;
    logic                 ev_released;
    logic                 ev_fail;
    logic                 ev_stop;

    hkcd_ram #(
        .WIDTH (1),
        .DEPTH (hkcd_pkg::KEY_SPACE)
    ) u_key_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // select the shortcut under scan
    always_comb
    begin
        sel      = '0;
        sel_held = '0;
        for (int i = 0; i < NREG; i++)
        begin
            if (slot_cnt_reg == SLOT_W'(i))
            begin
                sel      = slot_reg[i];
                sel_held = held_reg[i];
            end
        end
        for (int j = 0; j < KM; j++)
        begin
            code[j] = sel[hkcd_pkg::CODE_LSB + KW * j +: KW];
        end
    end

    always_comb
    begin
        key_cnt        = sel[CW:1];
        eff_cnt        = (key_cnt > CW'(KEYS_PER_SHORTCUT)) ? CW'(KEYS_PER_SHORTCUT) : key_cnt;
        start_pos_wide = eff_cnt - CW'(1);
        slot_empty     = (key_cnt == '0);
        rd_pos         = cmd.slot_start ? start_pos_wide[PW-1:0] : pos_reg - PW'(1);
        last_slot      = (slot_cnt_reg == SLOT_W'(NUM_SHORTCUTS - 1));
        fired          = !empty_reg && (release_reg ? (released_reg && cond_reg) : !fail_reg);
    end

    always_comb
    begin
        ram_we    = cmd.clr_step || (cmd.in_take && item.opcode == hkcd_pkg::OP_KEY);
        ram_waddr = cmd.clr_step ? clr_cnt_reg : item.key_code;
        ram_wdata = cmd.clr_step ? 1'b0 : item.key_is_down;
        ram_raddr = code[rd_pos];
    end

    // check one key, last to first
    always_comb
    begin
        held        = ram_rdata && (focused_reg || listen_reg);
        prev_held   = hist_reg[pos_reg];
        ev_hist     = hist_reg;
        ev_cond     = cond_reg;
        ev_released = released_reg;
        ev_fail     = fail_reg;
        ev_stop     = (pos_reg == '0);
        if (held)
        begin
            if (release_reg && !prev_held)
            begin
                ev_cond = 1'b0;
            end
            ev_hist[pos_reg] = 1'b1;
        end
        else
        begin
            ev_hist[pos_reg] = 1'b0;
            if (!release_reg)
            begin
                ev_fail = 1'b1;
                ev_stop = 1'b1;
            end
            else if (prev_held)
            begin
                ev_released = 1'b1;
            end
            else
            begin
                ev_cond = 1'b0;
                ev_stop = 1'b1;
            end
        end
    end

    always_comb
    begin
        listen_next       = listen_reg;
        slot_next         = slot_reg;
        held_next         = held_reg;
        clr_cnt_next      = clr_cnt_reg;
        slot_cnt_next     = slot_cnt_reg;
        pos_next          = pos_reg;
        hist_next         = hist_reg;
        release_next      = release_reg;
        cond_next         = cond_reg;
        released_next     = released_reg;
        fail_next         = fail_reg;
        empty_next        = empty_reg;
        focused_next      = focused_reg;
        result_valid_next = result_valid_reg;
        result_next       = result_reg;

        if (cmd.clr_step)
        begin
            clr_cnt_next = clr_cnt_reg + KW'(1);
        end

        if (cfg_we)
        begin
            for (int i = 0; i < NREG; i++)
            begin
                if (cfg_index == hkcd_pkg::CFG_IDX_W'(i))
                begin
                    slot_next[i] = cfg_data;
                    held_next[i] = '0;
                end
            end
            if (cfg_index == hkcd_pkg::CFG_LISTEN)
            begin
                listen_next = cfg_data[0];
            end
        end

        if (cmd.in_take && item.opcode == hkcd_pkg::OP_SCAN)
        begin
            focused_next = item.window_focused;
        end

        if (cmd.slot_start)
        begin
            pos_next      = start_pos_wide[PW-1:0];
            hist_next     = sel_held;
            release_next  = sel[0];
            cond_next     = 1'b1;
            released_next = 1'b0;
            fail_next     = 1'b0;
            empty_next    = slot_empty;
        end

        if (cmd.eval)
        begin
            pos_next      = pos_reg - PW'(1);
            hist_next     = ev_hist;
            cond_next     = ev_cond;
            released_next = ev_released;
            fail_next     = ev_fail;
        end

        if (cmd.done_load)
        begin
            result_valid_next          = 1'b1;
            result_next.shortcut_index = hkcd_pkg::IDX_W'(slot_cnt_reg);
            result_next.fired          = fired;
            result_next.last_of_scan   = last_slot;
            if (!empty_reg)
            begin
                for (int i = 0; i < NREG; i++)
                begin
                    if (slot_cnt_reg == SLOT_W'(i))
                    begin
                        held_next[i] = hist_reg;
                    end
                end
            end
            slot_cnt_next = last_slot ? '0 : slot_cnt_reg + SLOT_W'(1);
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            listen_reg       <= 1'b0;
            for (int i = 0; i < NREG; i++)
            begin
                slot_reg[i] <= '0;
                held_reg[i] <= '0;
            end
            clr_cnt_reg      <= '0;
            slot_cnt_reg     <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            listen_reg       <= listen_next;
            slot_reg         <= slot_next;
            held_reg         <= held_next;
            clr_cnt_reg      <= clr_cnt_next;
            slot_cnt_reg     <= slot_cnt_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        hist_reg     <= hist_next;
        release_reg  <= release_next;
        cond_reg     <= cond_next;
        released_reg <= released_next;
        fail_reg     <= fail_next;
        empty_reg    <= empty_next;
        focused_reg  <= focused_next;
        result_reg   <= result_next;
    end

    always_comb
    begin
        stat.clear_last = (clr_cnt_reg == KW'(hkcd_pkg::KEY_SPACE - 1));
        stat.scan_req   = (item.opcode == hkcd_pkg::OP_SCAN);
        stat.slot_empty = slot_empty;
        stat.eval_stop  = ev_stop;
        stat.out_free   = !result_valid_reg || !result_stall;
        stat.last_slot  = last_slot;
        result_valid    = result_valid_reg;
        result          = result_reg;
    end

endmodule
